// ===== rtl/core/angle_unwrap_rpm_meter_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the angle unwrap rpm meter
// Shared shorthand for concurrent checks clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ANGLE_UNWRAP_RPM_METER_MACROS_SVH
`define ANGLE_UNWRAP_RPM_METER_MACROS_SVH

// same-cycle implication
`define AURM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aurm check failed");

// next-cycle implication
`define AURM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aurm check failed");

`endif

// ===== rtl/core/aurm_pkg.sv =====
// ----------------------------------------------------------------------------
// aurm_pkg
// Widths, register indexes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aurm_pkg;

	localparam int DEG_W = 9;    // whole degrees 0..360
	localparam int ACC_W = 25;   // signed running sum of steps
	localparam int CNT_W = 16;   // step counter
	localparam int CFG_W = 16;   // widest config register
	localparam int NUM_W = 38;   // |total| * 8000
	localparam int DEN_W = 18;   // 3 * duration

	// config register indexes
	localparam logic REG_WINDOW_SAMPLES = 1'b0;
	localparam logic REG_SAMPLE_DURATION = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIV_START,
		ST_DIV,
		ST_DONE
	} aurm_state_t;

	typedef struct packed {
		logic load_deg;
		logic update;
		logic div_start;
		logic load_out;
	} aurm_cmd_t;

	typedef struct packed {
		logic have_ref;
		logic window_end;
		logic div_done;
		logic out_free;
	} aurm_status_t;

endpackage

// ===== rtl/core/angle_unwrap_rpm_meter.sv =====
// A sample inside a window passes through intake (IDLE) and update (UPDATE).
// The sample that closes a window then runs the 38-step serial divider and
// waits in DONE for room in the output register; input is stalled meanwhile.
// A new sample is taken only after the previous one has been folded in.
// Reset (arst_n low, asynchronous): sequencer idle, window cleared, next
// sample is the reference, output empty, both config registers back to 1000.
// ----------------------------------------------------------------------------
// angle_unwrap_rpm_meter
// Unwraps 12-bit encoder angles into a degree total per window and reports
// the speed in 1/16 rpm.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module angle_unwrap_rpm_meter
	import aurm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration write port
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [CFG_W-1:0]        cfg_wdata,
	// sample channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [7:0]              angle_high_byte,
	input  logic [7:0]              angle_low_byte,
	// result channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [31:0]      rpm_sixteenths,
	output logic signed [ACC_W-1:0] total_degrees
);

	// Controller and datapath talk only through these two bundles.
	aurm_cmd_t    cmd;
	aurm_status_t status;

	// Sequencer: IDLE takes a sample, UPDATE folds it into the window,
	// then at window end DIV_START/DIV run the divider and DONE waits for
	// room in the output register.
	aurm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	// Datapath: degree scaling (shift-add plus one correction for /4095),
	// unwrap and accumulate, |total|*8000 over 3*duration in a bit-serial
	// divider, signed saturation, result register. The result register lets
	// new samples in while a finished result still waits downstream.
	aurm_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.angle_high_byte (angle_high_byte),
		.angle_low_byte  (angle_low_byte),
		.cmd             (cmd),
		.status          (status),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.rpm_sixteenths  (rpm_sixteenths),
		.total_degrees   (total_degrees)
	);

endmodule

// ===== rtl/core/aurm_div.sv =====
// ----------------------------------------------------------------------------
// aurm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aurm_div
	import aurm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic [NUM_W-1:0] quotient,
	output logic             done
);

	localparam int ITER_W = $clog2(NUM_W);
	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(NUM_W - 1);

	logic [NUM_W-1:0] dvd_q;   // dividend shifts out, quotient shifts in
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [ITER_W-1:0] iter_q;
	logic busy_q;
	logic done_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] trial_sub;
	logic           qbit;

	always_comb begin
		trial = {rem_q, dvd_q[NUM_W-1]};
		trial_sub = trial - {1'b0, den_q};
		qbit = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == ITER_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[NUM_W-2:0], qbit};
			rem_q <= qbit ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign quotient = dvd_q;
	assign done = done_q;

endmodule

// ===== rtl/core/aurm_dp.sv =====
// ----------------------------------------------------------------------------
// aurm_dp
// Datapath: config registers, angle scaling, unwrap/accumulate, rpm division,
// saturation and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aurm_dp
	import aurm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [CFG_W-1:0]        cfg_wdata,
	input  logic [7:0]              angle_high_byte,
	input  logic [7:0]              angle_low_byte,
	input  aurm_cmd_t               cmd,
	output aurm_status_t            status,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [31:0]      rpm_sixteenths,
	output logic signed [ACC_W-1:0] total_degrees
);

	localparam logic [12:0] RAW_FULL_SCALE = 13'd4095;
	localparam logic signed [10:0] HALF_TURN = 11'sd180;
	localparam logic signed [10:0] FULL_TURN = 11'sd360;

	// config
	logic [CFG_W-1:0] window_q;
	logic [CFG_W-1:0] duration_q;

	// window state
	logic [DEG_W-1:0]        deg_q;
	logic [DEG_W-1:0]        prev_q;
	logic                    have_ref_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0]        count_q;
	logic                    neg_q;

	// output register
	logic                    out_valid_q;
	logic signed [31:0]      rpm_q;
	logic signed [ACC_W-1:0] total_q;

	// raw angle -> degrees: raw*360/4095 via shift-add and one correction
	logic [11:0] raw;
	logic [20:0] raw_ext;
	logic [20:0] scaled;
	logic [8:0]  q0;
	logic [12:0] r0;
	logic [DEG_W-1:0] deg;

	always_comb begin
		raw = {angle_high_byte[3:0], angle_low_byte};
		raw_ext = {9'd0, raw};
		scaled = (raw_ext << 8) + (raw_ext << 6) + (raw_ext << 5) + (raw_ext << 3);
		q0 = scaled[20:12];
		// x - q0*4095 = low 12 bits + q0, below twice the divisor
		r0 = {1'b0, scaled[11:0]} + {4'd0, q0};
		deg = (r0 >= RAW_FULL_SCALE) ? q0 + 9'd1 : q0;
	end

	// unwrapped step
	logic signed [10:0] diff_raw;
	logic signed [10:0] diff;

	always_comb begin
		diff_raw = $signed({2'b00, deg_q}) - $signed({2'b00, prev_q});
		if (diff_raw < -HALF_TURN)
			diff = diff_raw + FULL_TURN;
		else if (diff_raw > HALF_TURN)
			diff = diff_raw - FULL_TURN;
		else
			diff = diff_raw;
	end

	logic [CNT_W:0]   cnt_inc;
	logic [CFG_W-1:0] limit;
	logic [CFG_W-1:0] dur;

	always_comb begin
		cnt_inc = {1'b0, count_q} + 17'd1;
		limit = (window_q == '0) ? CFG_W'(1) : window_q;
		dur = (duration_q == '0) ? CFG_W'(1) : duration_q;
	end

	// divider operands: |acc| * 8000 and 3 * duration
	logic [ACC_W-1:0] acc_mag;
	logic [NUM_W-1:0] mag_ext;
	logic [NUM_W-1:0] dividend;
	logic [DEN_W-1:0] divisor;

	always_comb begin
		acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		mag_ext = {{(NUM_W-ACC_W){1'b0}}, acc_mag};
		// 8000 = 8192 - 128 - 64
		dividend = (mag_ext << 13) - (mag_ext << 7) - (mag_ext << 6);
		divisor = {2'b00, dur} + {1'b0, dur, 1'b0};
	end

	logic [NUM_W-1:0] quot;
	logic             div_done;

	aurm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.quotient (quot),
		.done     (div_done)
	);

	// saturate to 32-bit signed
	logic        pos_over;
	logic        neg_over;
	logic [31:0] rpm_sat;

	always_comb begin
		pos_over = |quot[NUM_W-1:31];
		neg_over = (|quot[NUM_W-1:32]) || (quot[31] && (|quot[30:0]));
		if (!neg_q)
			rpm_sat = pos_over ? 32'h7FFF_FFFF : quot[31:0];
		else
			rpm_sat = neg_over ? 32'h8000_0000 : 32'(-quot[31:0]);
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= CFG_W'(1000);
			duration_q <= CFG_W'(1000);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_SAMPLES:  window_q <= cfg_wdata;
				REG_SAMPLE_DURATION: duration_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			have_ref_q <= 1'b0;
			acc_q <= '0;
			count_q <= '0;
		end else if (cmd.update) begin
			prev_q <= deg_q;
			if (!have_ref_q) begin
				have_ref_q <= 1'b1;
			end else begin
				acc_q <= acc_q + {{(ACC_W-11){diff[10]}}, diff};
				count_q <= cnt_inc[CNT_W-1:0];
			end
		end else if (cmd.load_out) begin
			have_ref_q <= 1'b0;
			acc_q <= '0;
			count_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_deg)
			deg_q <= deg;
		if (cmd.div_start)
			neg_q <= acc_q[ACC_W-1];
		if (cmd.load_out) begin
			rpm_q <= $signed(rpm_sat);
			total_q <= acc_q;
		end
	end

	always_comb begin
		status.have_ref = have_ref_q;
		status.window_end = (cnt_inc >= {1'b0, limit});
		status.div_done = div_done;
		status.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign rpm_sixteenths = rpm_q;
	assign total_degrees = total_q;

endmodule

// ===== rtl/core/aurm_ctrl.sv =====
// ----------------------------------------------------------------------------
// aurm_ctrl
// Sequencer: sample intake, window update, divide and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "angle_unwrap_rpm_meter_macros.svh"

module aurm_ctrl
	import aurm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  aurm_status_t status,
	output aurm_cmd_t    cmd,
	output logic         in_stall
);

	aurm_state_t state_q;
	aurm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (status.have_ref && status.window_end)
					state_d = ST_DIV_START;
				else
					state_d = ST_IDLE;
			end
			ST_DIV_START: state_d = ST_DIV;
			ST_DIV: begin
				if (status.div_done)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load_deg = in_valid;
			end
			ST_UPDATE:    cmd.update = 1'b1;
			ST_DIV_START: cmd.div_start = 1'b1;
			ST_DIV:       ;
			ST_DONE:      cmd.load_out = status.out_free;
			default:      ;
		endcase
	end

	`AURM_ASSERT_NXT(a_accept_to_update, in_valid && !in_stall, state_q == ST_UPDATE)
	`AURM_ASSERT_IMP(a_no_result_overwrite, cmd.load_out, status.out_free)
	`AURM_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0(cmd))
	`AURM_ASSERT_IMP(a_done_in_div, status.div_done, state_q == ST_DIV)

endmodule
